// ----- hw/rtl/rate_half_trellis_codec_defines.svh -----
// Assertion macros shared by the rate one-half trellis codec RTL.
`ifndef RATE_HALF_TRELLIS_CODEC_DEFINES_SVH
`define RATE_HALF_TRELLIS_CODEC_DEFINES_SVH

`ifndef SYNTH
`define RTHC_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("rthc assertion failed");
`define RTHC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("rthc assertion failed");
`else
`define RTHC_ASSERT_IMPL(lbl, cond, prop)
`define RTHC_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// ----- hw/rtl/rthc_pkg.sv -----
// Types, trellis word table and helpers for the rate one-half trellis codec.
`default_nettype none
package rthc_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [3:0] symbol;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [3:0] out_value;
    logic       error;
    logic [7:0] error_position;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       res_a;
    out_t       res_b;
  } push_t;

  function automatic logic [3:0] trellis_word(input logic [1:0] st, input logic [1:0] d);
    logic [3:0] w;
    begin
      w = 4'h0;
      case ({st, d})
        4'h0: w = 4'h2;
        4'h1: w = 4'hc;
        4'h2: w = 4'h1;
        4'h3: w = 4'hf;
        4'h4: w = 4'he;
        4'h5: w = 4'h0;
        4'h6: w = 4'hd;
        4'h7: w = 4'h3;
        4'h8: w = 4'h9;
        4'h9: w = 4'h7;
        4'ha: w = 4'ha;
        4'hb: w = 4'h4;
        4'hc: w = 4'h5;
        4'hd: w = 4'hb;
        4'he: w = 4'h6;
        default: w = 4'h8;
      endcase
      return w;
    end
  endfunction

  function automatic logic [2:0] ones4(input logic [3:0] v);
    return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rthc_engine.sv -----
// Input register, frame state and combinational encode/decode step.
`default_nettype none
module rthc_engine #(
  parameter int MAX_FRAME_SYMBOLS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rthc_pkg::in_t in_data,
  input  wire logic          q_space,
  output rthc_pkg::push_t    push
);

  localparam int unsigned IDX_LIMIT_I =
    ((MAX_FRAME_SYMBOLS - 1) > 255) ? 255 : (MAX_FRAME_SYMBOLS - 1);
  localparam logic [7:0] IDX_LIMIT = 8'(IDX_LIMIT_I);

  logic          in_vld_r;
  rthc_pkg::in_t in_buf_r;
  logic          dir_r;
  logic [1:0]    ts_r, ts_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic          el_r, el_nxt;
  logic [7:0]    ei_r, ei_nxt;
  logic          take;
  logic [7:0]    idx_adv;
  logic [1:0]    best;
  logic [2:0]    bestd;
  logic [2:0]    ties;

  assign take     = in_vld_r && q_space;
  assign in_ready = !in_vld_r || q_space;
  assign idx_adv  = (idx_r < IDX_LIMIT) ? idx_r + 8'd1 : idx_r;

  always_comb begin
    logic [2:0] ham;
    best  = 2'd0;
    bestd = 3'd5;
    ties  = 3'd0;
    for (int j = 0; j < 4; j++) begin
      ham = rthc_pkg::ones4(in_buf_r.symbol ^ rthc_pkg::trellis_word(ts_r, 2'(j)));
      if (ham < bestd) begin
        bestd = ham;
        best  = 2'(j);
        ties  = 3'd1;
      end else if (ham == bestd) begin
        ties = ties + 3'd1;
      end
    end
  end

  always_comb begin
    logic [1:0] d;
    d       = in_buf_r.symbol[1:0];
    ts_nxt  = ts_r;
    idx_nxt = idx_r;
    el_nxt  = el_r;
    ei_nxt  = ei_r;
    push    = '0;
    if (take) begin
      if (dir_r == rthc_pkg::DIR_ENCODE) begin
        push.res_a.out_value = rthc_pkg::trellis_word(ts_r, d);
        if (in_buf_r.frame_last) begin
          push.count                = 2'd2;
          push.res_b.out_value      = rthc_pkg::trellis_word(d, 2'd0);
          push.res_b.out_last       = 1'b1;
          ts_nxt                    = 2'd0;
          idx_nxt                   = 8'd0;
          el_nxt                    = 1'b0;
          ei_nxt                    = 8'd0;
        end else begin
          push.count = 2'd1;
          ts_nxt     = d;
          idx_nxt    = idx_adv;
        end
      end else if (in_buf_r.frame_last) begin
        push.count                = 2'd1;
        push.res_a.error          = el_r;
        push.res_a.error_position = el_r ? ei_r : 8'd0;
        push.res_a.out_last       = 1'b1;
        ts_nxt                    = 2'd0;
        idx_nxt                   = 8'd0;
        el_nxt                    = 1'b0;
        ei_nxt                    = 8'd0;
      end else if (el_r) begin
        idx_nxt = idx_adv;
      end else if (ties != 3'd1) begin
        el_nxt  = 1'b1;
        ei_nxt  = idx_r;
        idx_nxt = idx_adv;
      end else begin
        push.count           = 2'd1;
        push.res_a.out_value = {2'b00, best};
        ts_nxt               = best;
        idx_nxt              = idx_adv;
      end
    end
    if (cfg_wr_en) begin
      ts_nxt  = 2'd0;
      idx_nxt = 8'd0;
      el_nxt  = 1'b0;
      ei_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      dir_r    <= rthc_pkg::DIR_ENCODE;
      ts_r     <= 2'd0;
      idx_r    <= 8'd0;
      el_r     <= 1'b0;
      ei_r     <= 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (take) begin
        in_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        dir_r <= cfg_wr_data;
      end
      ts_r  <= ts_nxt;
      idx_r <= idx_nxt;
      el_r  <= el_nxt;
      ei_r  <= ei_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buf_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rthc_outq.sv -----
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none
module rthc_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rthc_pkg::push_t push,
  output logic                 q_space,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rthc_pkg::out_t       out_data
);

  localparam int DEPTH = 4;

  rthc_pkg::out_t mem_r [DEPTH];
  logic [1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [2:0]     count_r, count_nxt;
  logic           pop;

  assign out_valid  = count_r != 3'd0;
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign q_space    = count_r <= 3'(DEPTH - 2);
  assign wr_ptr_nxt = wr_ptr_r + push.count;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, push.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.res_b;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rate_half_trellis_codec.sv -----
// An accepted request waits in the engine input register until the output queue has room.
// Throughput: one request per cycle while the output queue has room; an encode frame end adds a second result.
// The single output port, one result per cycle, bounds the sustained rate.
// Reset (synchronous, rst_n low) empties both stages, sets encode and clears frame state.
`default_nettype none
`include "rate_half_trellis_codec_defines.svh"
module rate_half_trellis_codec #(
  parameter int MAX_FRAME_SYMBOLS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rthc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rthc_pkg::out_t      out_data
);

  rthc_pkg::push_t push;
  logic            q_space;

  rthc_engine #(
    .MAX_FRAME_SYMBOLS(MAX_FRAME_SYMBOLS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_space     (q_space),
    .push        (push)
  );

  rthc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RTHC_ASSERT_IMPL(a_push_room, push.count != 2'd0, q_space)
  `RTHC_ASSERT_IMPL(a_pair_order, push.count == 2'd2, push.res_b.out_last && !push.res_a.out_last)
  `RTHC_ASSERT_IMPL(a_err_on_end, push.count != 2'd0 && push.res_a.error, push.res_a.out_last)
  `RTHC_ASSERT_NEXT(a_pair_fills, push.count == 2'd2 && !out_valid, out_valid)

endmodule
`default_nettype wire
